>>> hdl/i2c_mbs_pkg.sv
// ----------------------------------------------------------------------------
// i2c_mbs_pkg
// Shared types and constants of the I2C master bit sequencer: command codes,
// sequencer phases, delay unit multipliers and the sequencer state record.
// ----------------------------------------------------------------------------
`default_nettype none

package i2c_mbs_pkg;

   // command codes carried by each tick
   localparam logic [2:0] CMD_NONE  = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_STOP  = 3'd2;
   localparam logic [2:0] CMD_WRITE = 3'd3;
   localparam logic [2:0] CMD_READ  = 3'd4;
   localparam logic [2:0] CMD_WAIT  = 3'd5;

   // configuration register indexes
   localparam logic CSR_UNIT_TICKS  = 1'b0;
   localparam logic CSR_ACK_TIMEOUT = 1'b1;

   // configuration reset values
   localparam logic [15:0] UNIT_TICKS_RESET  = 16'd1;
   localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd250;

   // bits per byte transfer on the bus
   localparam int unsigned BYTE_BITS = 8;

   // sequencer phases
   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_ST_HI   = 4'd1,
      PH_ST_LO   = 4'd2,
      PH_SP_LO   = 4'd3,
      PH_SP_HI   = 4'd4,
      PH_WA_REL  = 4'd5,
      PH_WA_CLK  = 4'd6,
      PH_WA_POLL = 4'd7,
      PH_WR_DAT  = 4'd8,
      PH_WR_CKH  = 4'd9,
      PH_WR_CKL  = 4'd10,
      PH_RD_LOW  = 4'd11,
      PH_RD_HIGH = 4'd12,
      PH_AK_SET  = 4'd13,
      PH_AK_CLK  = 4'd14
   } phase_type;

   // delay length of a step in units
   typedef enum logic [1:0] {
      UNITS_1 = 2'd0,
      UNITS_2 = 2'd1,
      UNITS_4 = 2'd2
   } units_type;

   // sequencer state apart from the delay timer
   typedef struct packed {
      phase_type  phase;
      logic [3:0] bit_index;
      logic [7:0] shift_reg;
      logic [7:0] poll_count;
      logic       scl;
      logic       sda;
      logic       ack_choice;
      logic       error_flag;
      logic [7:0] rx_hold;
   } seq_state_type;

   localparam seq_state_type SEQ_STATE_RESET = '{
      phase:      PH_IDLE,
      bit_index:  4'd0,
      shift_reg:  8'd0,
      poll_count: 8'd0,
      scl:        1'b1,
      sda:        1'b1,
      ack_choice: 1'b0,
      error_flag: 1'b0,
      rx_hold:    8'd0
   };

endpackage

`default_nettype wire

>>> hdl/i2c_mbs_delay.sv
// ----------------------------------------------------------------------------
// i2c_mbs_delay
// Step delay in ticks: unit_ticks times one, two or four units, with a zero
// unit read as one tick and the result saturated at the timer maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_mbs_delay
   import i2c_mbs_pkg::*;
#(
   parameter int TIMER_WIDTH = 19
) (
   input  wire logic [15:0]            unit_ticks,
   input  wire units_type              units,
   output logic      [TIMER_WIDTH-1:0] delay
);

   localparam int PW = 18;
   localparam int XW = (TIMER_WIDTH > PW) ? TIMER_WIDTH : PW;

   logic [15:0]   unit_eff;
   logic [PW-1:0] prod;
   logic [XW-1:0] prod_x;
   logic [XW-1:0] max_x;

   // zero unit counts as one tick
   assign unit_eff = (unit_ticks == 16'd0) ? 16'd1 : unit_ticks;

   // multiply by a power of two
   always_comb begin
      unique case (units)
         UNITS_1: prod = {2'b00, unit_eff};
         UNITS_2: prod = {1'b0, unit_eff, 1'b0};
         UNITS_4: prod = {unit_eff, 2'b00};
         default: prod = {2'b00, unit_eff};
      endcase
   end

   // saturate at the timer maximum
   assign prod_x = XW'(prod);
   assign max_x  = XW'({TIMER_WIDTH{1'b1}});
   assign delay  = (prod_x > max_x) ? {TIMER_WIDTH{1'b1}} : prod_x[TIMER_WIDTH-1:0];

endmodule

`default_nettype wire

>>> hdl/i2c_mbs_step.sv
// ----------------------------------------------------------------------------
// i2c_mbs_step
// Next-state logic for one tick: command decode while idle, acknowledge
// polling, delay countdown and the bit sequence of each command.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_mbs_step
   import i2c_mbs_pkg::*;
#(
   parameter int TIMER_WIDTH = 19
) (
   input  wire seq_state_type          cur_state,
   input  wire logic [TIMER_WIDTH-1:0] cur_delay,
   input  wire logic [2:0]             command,
   input  wire logic [7:0]             tx_byte,
   input  wire logic                   send_ack,
   input  wire logic                   sda_sample,
   input  wire logic [15:0]            unit_ticks,
   input  wire logic [7:0]             ack_timeout,
   output seq_state_type               nxt_state,
   output logic      [TIMER_WIDTH-1:0] nxt_delay,
   output logic                        done
);

   seq_state_type          n;
   logic                   go_en;
   units_type              go_units;
   logic                   finish;
   logic                   do_poll;
   logic [7:0]             poll_base;
   logic [TIMER_WIDTH-1:0] dec;
   logic [TIMER_WIDTH-1:0] go_delay;
   logic [3:0]             bit_inc;

   i2c_mbs_delay #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_delay (
      .unit_ticks (unit_ticks),
      .units      (go_units),
      .delay      (go_delay)
   );

   assign dec     = (cur_delay != '0) ? cur_delay - TIMER_WIDTH'(1) : cur_delay;
   assign bit_inc = cur_state.bit_index + 4'd1;

   // phase sequencing
   always_comb begin
      n         = cur_state;
      go_en     = 1'b0;
      go_units  = UNITS_1;
      finish    = 1'b0;
      do_poll   = 1'b0;
      poll_base = cur_state.poll_count;

      priority if (cur_state.phase == PH_IDLE) begin
         // commands are taken only while idle
         unique case (command)
            CMD_START: begin
               n.sda = 1'b1; n.scl = 1'b1;
               n.phase = PH_ST_HI; go_en = 1'b1; go_units = UNITS_4;
            end
            CMD_STOP: begin
               n.scl = 1'b0; n.sda = 1'b0;
               n.phase = PH_SP_LO; go_en = 1'b1; go_units = UNITS_4;
            end
            CMD_WRITE: begin
               n.bit_index = 4'd0;
               n.scl = 1'b0; n.sda = tx_byte[7];
               n.shift_reg = {tx_byte[6:0], 1'b0};
               n.phase = PH_WR_DAT; go_en = 1'b1; go_units = UNITS_2;
            end
            CMD_READ: begin
               n.ack_choice = send_ack; n.shift_reg = 8'd0; n.bit_index = 4'd0;
               n.scl = 1'b0; n.sda = 1'b1;
               n.phase = PH_RD_LOW; go_en = 1'b1; go_units = UNITS_2;
            end
            CMD_WAIT: begin
               n.error_flag = 1'b0; n.poll_count = 8'd0; n.sda = 1'b1;
               n.phase = PH_WA_REL; go_en = 1'b1; go_units = UNITS_1;
            end
            default: ;
         endcase
      end else if (cur_state.phase == PH_WA_POLL) begin
         do_poll = 1'b1;
      end else if (dec == '0) begin
         // step ends on this tick
         unique case (cur_state.phase)
            PH_ST_HI: begin
               n.sda = 1'b0; n.phase = PH_ST_LO; go_en = 1'b1; go_units = UNITS_4;
            end
            PH_ST_LO: begin
               n.scl = 1'b0; finish = 1'b1;
            end
            PH_SP_LO: begin
               n.scl = 1'b1; n.sda = 1'b1;
               n.phase = PH_SP_HI; go_en = 1'b1; go_units = UNITS_4;
            end
            PH_WA_REL: begin
               n.scl = 1'b1; n.phase = PH_WA_CLK; go_en = 1'b1; go_units = UNITS_1;
            end
            PH_WA_CLK: begin
               n.phase = PH_WA_POLL; do_poll = 1'b1; poll_base = 8'd0;
            end
            PH_WR_DAT: begin
               n.scl = 1'b1; n.phase = PH_WR_CKH; go_en = 1'b1; go_units = UNITS_2;
            end
            PH_WR_CKH: begin
               n.scl = 1'b0; n.phase = PH_WR_CKL; go_en = 1'b1; go_units = UNITS_2;
            end
            PH_WR_CKL: begin
               n.bit_index = bit_inc;
               if (bit_inc >= 4'(BYTE_BITS)) begin
                  finish = 1'b1;
               end else begin
                  n.scl = 1'b0; n.sda = cur_state.shift_reg[7];
                  n.shift_reg = {cur_state.shift_reg[6:0], 1'b0};
                  n.phase = PH_WR_DAT; go_en = 1'b1; go_units = UNITS_2;
               end
            end
            PH_RD_LOW: begin
               n.scl = 1'b1;
               n.shift_reg = {cur_state.shift_reg[6:0], sda_sample};
               n.bit_index = bit_inc;
               n.phase = PH_RD_HIGH; go_en = 1'b1; go_units = UNITS_1;
            end
            PH_RD_HIGH: begin
               if (cur_state.bit_index >= 4'(BYTE_BITS)) begin
                  n.rx_hold = cur_state.shift_reg;
                  n.scl = 1'b0; n.sda = ~cur_state.ack_choice;
                  n.phase = PH_AK_SET; go_en = 1'b1; go_units = UNITS_2;
               end else begin
                  n.scl = 1'b0; n.sda = 1'b1;
                  n.phase = PH_RD_LOW; go_en = 1'b1; go_units = UNITS_2;
               end
            end
            PH_AK_SET: begin
               n.scl = 1'b1; n.phase = PH_AK_CLK; go_en = 1'b1; go_units = UNITS_2;
            end
            PH_AK_CLK: begin
               n.scl = 1'b0; finish = 1'b1;
            end
            default: finish = 1'b1;
         endcase
      end else begin
         // delay still running, lines hold
      end

      // acknowledge poll, also on the tick that ends the clock-high step
      if (do_poll) begin
         n.poll_count = poll_base;
         priority if (!sda_sample) begin
            n.scl = 1'b0; finish = 1'b1;
         end else if (poll_base >= ack_timeout) begin
            n.error_flag = 1'b1; n.scl = 1'b0; n.sda = 1'b0;
            n.phase = PH_SP_LO; go_en = 1'b1; go_units = UNITS_4;
         end else begin
            n.poll_count = poll_base + 8'd1;
         end
      end

      if (finish) n.phase = PH_IDLE;
   end

   // delay timer update
   always_comb begin
      priority if (go_en) nxt_delay = go_delay;
      else if (finish)     nxt_delay = '0;
      else if (cur_state.phase == PH_IDLE || cur_state.phase == PH_WA_POLL)
         nxt_delay = cur_delay;
      else                 nxt_delay = dec;
   end

   assign nxt_state = n;
   assign done      = finish;

endmodule

`default_nettype wire

>>> hdl/i2c_master_bit_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// Tick-driven I2C master: start, stop, byte write, byte read and acknowledge
// wait sequences on SCL and SDA.
// ----------------------------------------------------------------------------
// Every req transfer is one timing tick and yields exactly one rsp transfer
// with the line levels, busy, done, the last read byte and the acknowledge
// error flag after that tick. The sequencer state is registered when the tick
// is accepted and the result sits in the rsp output register, so ticks can be
// sent every cycle while rsp_tready is high. A command is taken only on a
// tick where the sequencer is idle; each step holds the lines for 1, 2 or 4
// delay units of unit_ticks ticks, saturated at the TIMER_WIDTH-bit timer
// maximum. Write the csr registers only while no result is pending.
`default_nettype none

module i2c_master_bit_sequencer
   import i2c_mbs_pkg::*;
#(
   parameter int TIMER_WIDTH = 19
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // tick input
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // bits up: command[2:0], tx_byte[10:3], send_ack[11], sda_sample[12], zero
   input  wire logic [15:0] req_tdata,
   // result output
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // bits up: scl_level[0], sda_drive[1], busy_res[2], done_res[3],
   // rx_byte[11:4], ack_error[12], zero
   output logic      [15:0] rsp_tdata,
   // configuration writes
   input  wire logic        csr_wen,
   input  wire logic        csr_addr,
   input  wire logic [15:0] csr_wdata
);

   logic [15:0]            unit_ticks_ff;
   logic [7:0]             ack_timeout_ff;
   seq_state_type          state_ff;
   seq_state_type          state_in;
   logic [TIMER_WIDTH-1:0] delay_ff;
   logic [TIMER_WIDTH-1:0] delay_in;
   logic                   step_done;
   logic                   req_xfer;
   logic                   rsp_tvalid_ff;
   logic                   rsp_tvalid_in;
   logic [15:0]            rsp_tdata_ff;
   logic [15:0]            rsp_tdata_in;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ticks_ff  <= UNIT_TICKS_RESET;
         ack_timeout_ff <= ACK_TIMEOUT_RESET;
      end else if (csr_wen) begin
         unique case (csr_addr)
            CSR_UNIT_TICKS:  unit_ticks_ff  <= csr_wdata;
            CSR_ACK_TIMEOUT: ack_timeout_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // accept a tick when the output register is free or draining
   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;

   i2c_mbs_step #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_step (
      .cur_state   (state_ff),
      .cur_delay   (delay_ff),
      .command     (req_tdata[2:0]),
      .tx_byte     (req_tdata[10:3]),
      .send_ack    (req_tdata[11]),
      .sda_sample  (req_tdata[12]),
      .unit_ticks  (unit_ticks_ff),
      .ack_timeout (ack_timeout_ff),
      .nxt_state   (state_in),
      .nxt_delay   (delay_in),
      .done        (step_done)
   );

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_STATE_RESET;
         delay_ff <= '0;
      end else if (req_xfer) begin
         state_ff <= state_in;
         delay_ff <= delay_in;
      end
   end

   // result register
   assign rsp_tvalid_in = req_xfer || (rsp_tvalid_ff && !rsp_tready);
   assign rsp_tdata_in  = {3'b000, state_in.error_flag, state_in.rx_hold, step_done,
                           (state_in.phase != PH_IDLE), state_in.sda, state_in.scl};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

`default_nettype wire

>>> hdl/i2c_mbs_checker.sv
// ----------------------------------------------------------------------------
// i2c_mbs_checker
// Port-level checks of the I2C master bit sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_mbs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp changed while stalled");

   // every accepted tick produces a result
   a_tick_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted tick without result");

   // an empty output register never stalls the input
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // done only on the tick the sequencer goes idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> !rsp_tdata[2])
      else $error("done while busy");

endmodule

bind i2c_master_bit_sequencer i2c_mbs_checker u_checker (.*);

`default_nettype wire

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the I2C master bit sequencer. Ticks go in on the
// req stream and every tick yields one line-state word on the rsp stream. A
// predictor follows the sequencer tick by tick and its words are compared
// field by field with what comes out. A directed table walks every command,
// busy and reserved commands, acknowledge and timeout on both timeout
// extremes and a zero unit_ticks. Random phases under several settings
// follow, with random gaps on both streams and one long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import i2c_mbs_pkg::*;

   localparam int unsigned     TIMER_W     = 19;
   localparam longint unsigned TIMER_MAX   = (64'd1 << TIMER_W) - 64'd1;
   localparam logic [2:0]      CMD_RSVD6   = 3'd6;
   localparam logic [2:0]      CMD_RSVD7   = 3'd7;
   localparam int              GAP_MAX     = 13;
   localparam int              HOLD_CYCLES = 64;
   localparam int              HOLD_AFTER  = 200;
   localparam int              REPORT_MAX  = 10;
   localparam int              PHASE_TICKS = 80;
   localparam int              N_PLAN      = 23;
   localparam int              N_SETTINGS  = 7;

   // req_tdata layout, lowest bit first: command, tx_byte, send_ack, sda_sample
   typedef struct packed {
      logic [2:0] pad;
      logic       sda_sample;
      logic       send_ack;
      logic [7:0] tx_byte;
      logic [2:0] command;
   } bus_tick_t;

   // rsp_tdata layout, lowest bit first: scl, sda, busy, done, rx_byte, ack_error
   typedef struct packed {
      logic [2:0] pad;
      logic       ack_error;
      logic [7:0] rx_byte;
      logic       done;
      logic       busy;
      logic       sda;
      logic       scl;
   } line_word_t;

   // one row of the directed table: a csr setting or a command tick
   typedef struct packed {
      logic       is_csr;
      logic [15:0] unit;
      logic [7:0] tmo;
      logic [2:0] command;
      logic [7:0] tx_byte;
      logic       send_ack;
      logic       sda;
      logic [2:0] fill;
      logic       quiet;
      logic       typed;
      line_word_t want;
   } plan_row_t;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [15:0] req_tdata  = '0;
   logic        rsp_tready = 1'b0;
   logic        csr_wen    = 1'b0;
   logic        csr_addr   = 1'b0;
   logic [15:0] csr_wdata  = '0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [15:0] rsp_tdata;

   i2c_master_bit_sequencer #(
      .TIMER_WIDTH (TIMER_W)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5ns clock = ~clock;

   // predicted sequencer state and configuration
   phase_type       seq_phase = PH_IDLE;
   longint unsigned seq_timer = 0;
   logic [3:0]      seq_bits  = '0;
   logic [7:0]      seq_shift = '0;
   logic [7:0]      seq_polls = '0;
   logic            seq_scl   = 1'b1;
   logic            seq_sda   = 1'b1;
   logic            seq_ack   = 1'b0;
   logic            seq_err   = 1'b0;
   logic [7:0]      seq_rx    = '0;
   logic            seq_done  = 1'b0;
   logic [15:0]     cfg_unit  = UNIT_TICKS_RESET;
   logic [7:0]      cfg_tmo   = ACK_TIMEOUT_RESET;

   line_word_t expected_lines [$];
   bit         gaps_on      = 1'b1;
   int         fail_count   = 0;
   int         mismatches   = 0;
   int         results_seen = 0;
   int         ticks_sent   = 0;
   int         ack_timeouts = 0;
   int         cmd_taken [8];

   plan_row_t plan [N_PLAN];

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   // hold the lines for a number of delay units, saturated at the timer max
   function automatic void arm_delay(phase_type nxt, int unsigned units);
      longint unsigned span;
      span = (cfg_unit == 16'd0) ? 64'(units) : 64'(cfg_unit) * 64'(units);
      if (span > TIMER_MAX) span = TIMER_MAX;
      if (span == 0) span = 1;
      seq_phase = nxt;
      seq_timer = span;
   endfunction

   function automatic void end_sequence();
      seq_phase = PH_IDLE;
      seq_timer = 0;
      seq_done  = 1'b1;
   endfunction

   // put the next bit of the byte on sda with scl low, msb first
   function automatic void start_bit_out();
      seq_scl   = 1'b0;
      seq_sda   = seq_shift[7];
      seq_shift = {seq_shift[6:0], 1'b0};
      arm_delay(PH_WR_DAT, 2);
   endfunction

   function automatic void start_bit_in();
      seq_scl = 1'b0;
      seq_sda = 1'b1;
      arm_delay(PH_RD_LOW, 2);
   endfunction

   // one acknowledge poll while scl is high
   function automatic void check_ack(logic s);
      if (!s) begin
         seq_scl = 1'b0;
         end_sequence();
      end else if (seq_polls >= cfg_tmo) begin
         seq_err = 1'b1;
         seq_scl = 1'b0;
         seq_sda = 1'b0;
         arm_delay(PH_SP_LO, 4);
         ack_timeouts++;
      end else begin
         seq_polls = seq_polls + 8'd1;
      end
   endfunction

   // step taken when the current delay has run out
   function automatic void advance_step(logic s);
      case (seq_phase)
         PH_ST_HI: begin
            seq_sda = 1'b0;
            arm_delay(PH_ST_LO, 4);
         end
         PH_ST_LO: begin
            seq_scl = 1'b0;
            end_sequence();
         end
         PH_SP_LO: begin
            seq_scl = 1'b1;
            seq_sda = 1'b1;
            arm_delay(PH_SP_HI, 4);
         end
         PH_SP_HI: end_sequence();
         PH_WA_REL: begin
            seq_scl = 1'b1;
            arm_delay(PH_WA_CLK, 1);
         end
         PH_WA_CLK: begin
            seq_phase = PH_WA_POLL;
            seq_timer = 0;
            seq_polls = '0;
            check_ack(s);
         end
         PH_WR_DAT: begin
            seq_scl = 1'b1;
            arm_delay(PH_WR_CKH, 2);
         end
         PH_WR_CKH: begin
            seq_scl = 1'b0;
            arm_delay(PH_WR_CKL, 2);
         end
         PH_WR_CKL: begin
            seq_bits = seq_bits + 4'd1;
            if (seq_bits >= BYTE_BITS) end_sequence();
            else start_bit_out();
         end
         PH_RD_LOW: begin
            seq_scl   = 1'b1;
            seq_shift = {seq_shift[6:0], s};
            seq_bits  = seq_bits + 4'd1;
            arm_delay(PH_RD_HIGH, 1);
         end
         PH_RD_HIGH: begin
            if (seq_bits >= BYTE_BITS) begin
               seq_rx  = seq_shift;
               seq_scl = 1'b0;
               seq_sda = ~seq_ack;
               arm_delay(PH_AK_SET, 2);
            end else begin
               start_bit_in();
            end
         end
         PH_AK_SET: begin
            seq_scl = 1'b1;
            arm_delay(PH_AK_CLK, 2);
         end
         PH_AK_CLK: begin
            seq_scl = 1'b0;
            end_sequence();
         end
         default: end_sequence();
      endcase
   endfunction

   // line state after one accepted tick
   function automatic line_word_t predict_bus_tick(bus_tick_t t);
      line_word_t w;
      seq_done = 1'b0;
      if (seq_phase == PH_IDLE) begin
         if (t.command inside {[CMD_START:CMD_WAIT]}) cmd_taken[t.command]++;
         case (t.command)
            CMD_START: begin
               seq_sda = 1'b1;
               seq_scl = 1'b1;
               arm_delay(PH_ST_HI, 4);
            end
            CMD_STOP: begin
               seq_scl = 1'b0;
               seq_sda = 1'b0;
               arm_delay(PH_SP_LO, 4);
            end
            CMD_WRITE: begin
               seq_shift = t.tx_byte;
               seq_bits  = '0;
               start_bit_out();
            end
            CMD_READ: begin
               seq_ack   = t.send_ack;
               seq_shift = '0;
               seq_bits  = '0;
               start_bit_in();
            end
            CMD_WAIT: begin
               seq_err   = 1'b0;
               seq_polls = '0;
               seq_sda   = 1'b1;
               arm_delay(PH_WA_REL, 1);
            end
            default: ;
         endcase
      end else if (seq_phase == PH_WA_POLL) begin
         check_ack(t.sda_sample);
      end else begin
         if (seq_timer > 0) seq_timer--;
         if (seq_timer == 0) advance_step(t.sda_sample);
      end
      w           = '0;
      w.scl       = seq_scl;
      w.sda       = seq_sda;
      w.busy      = (seq_phase != PH_IDLE);
      w.done      = seq_done;
      w.rx_byte   = seq_rx;
      w.ack_error = seq_err;
      return w;
   endfunction

   // ------------------------------------------------------------------
   // table helpers
   // ------------------------------------------------------------------

   function automatic line_word_t lines(logic scl, logic sda, logic busy, logic done,
                                        logic [7:0] rx, logic err);
      line_word_t w;
      w = '{pad: 3'd0, ack_error: err, rx_byte: rx, done: done, busy: busy,
            sda: sda, scl: scl};
      return w;
   endfunction

   function automatic plan_row_t csr_row(logic [15:0] unit, logic [7:0] tmo);
      plan_row_t r;
      r        = '0;
      r.is_csr = 1'b1;
      r.unit   = unit;
      r.tmo    = tmo;
      return r;
   endfunction

   function automatic plan_row_t cmd_row(logic [2:0] command, logic [7:0] tx, logic ack,
                                         logic sda, logic [2:0] fill, logic quiet);
      plan_row_t r;
      r          = '0;
      r.command  = command;
      r.tx_byte  = tx;
      r.send_ack = ack;
      r.sda      = sda;
      r.fill     = fill;
      r.quiet    = quiet;
      return r;
   endfunction

   function automatic plan_row_t typed_row(logic [2:0] command, logic [7:0] tx, logic ack,
                                           logic sda, line_word_t want);
      plan_row_t r;
      r       = cmd_row(command, tx, ack, sda, CMD_NONE, 1'b0);
      r.typed = 1'b1;
      r.want  = want;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // stimulus tasks
   // ------------------------------------------------------------------

   // offer one tick after a random gap and record its expected line state
   task automatic send_tick(logic [2:0] command, logic [7:0] tx, logic ack, logic sda,
                            logic typed, line_word_t want);
      bus_tick_t   t;
      line_word_t  w;
      int unsigned gap;
      t   = '{pad: 3'd0, sda_sample: sda, send_ack: ack, tx_byte: tx, command: command};
      gap = gaps_on ? $urandom_range(0, GAP_MAX) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= t;
      do @(posedge clock); while (!req_tready);
      w = predict_bus_tick(t);
      expected_lines.push_back(typed ? want : w);
      ticks_sent++;
   endtask

   // keep ticking until the sequence in flight has completed
   task automatic run_to_idle(logic [2:0] fill, logic sda);
      while (seq_phase != PH_IDLE)
         send_tick(fill, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), sda,
                   1'b0, '0);
   endtask

   // write both registers once all pending results are in
   task automatic configure(logic [15:0] unit, logic [7:0] tmo);
      req_tvalid <= 1'b0;
      while (expected_lines.size() > 0) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_addr  <= CSR_UNIT_TICKS;
      csr_wdata <= unit;
      @(posedge clock);
      csr_addr  <= CSR_ACK_TIMEOUT;
      csr_wdata <= {8'd0, tmo};
      @(posedge clock);
      csr_wen   <= 1'b0;
      cfg_unit = unit;
      cfg_tmo  = tmo;
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      logic [15:0] set_unit [N_SETTINGS];
      logic [7:0]  set_tmo  [N_SETTINGS];
      logic [2:0]  tcmd;
      logic        tsda;
      int          pick;
      int          n;

      foreach (cmd_taken[k]) cmd_taken[k] = 0;

      plan = '{
         // idle lines right after reset
         typed_row(CMD_NONE,  8'h00, 1'b0, 1'b1,
                   lines(1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0)),
         typed_row(CMD_START, 8'h00, 1'b0, 1'b1,
                   lines(1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0)),
         // byte extremes on write
         typed_row(CMD_WRITE, 8'hFF, 1'b0, 1'b1,
                   lines(1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0)),
         typed_row(CMD_WRITE, 8'h00, 1'b0, 1'b0,
                   lines(1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0)),
         // commands while busy are dropped, up to the completing tick
         cmd_row(CMD_WRITE, 8'hA5, 1'b0, 1'b1, CMD_START, 1'b0),
         typed_row(CMD_READ,  8'h00, 1'b1, 1'b1,
                   lines(1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0)),
         cmd_row(CMD_READ,  8'h00, 1'b0, 1'b0, CMD_READ,  1'b0),
         // acknowledge seen, then a timeout at the reset limit
         cmd_row(CMD_WAIT,  8'h00, 1'b0, 1'b0, CMD_NONE,  1'b0),
         cmd_row(CMD_WAIT,  8'h00, 1'b0, 1'b1, CMD_WAIT,  1'b0),
         cmd_row(CMD_STOP,  8'h00, 1'b0, 1'b1, CMD_STOP,  1'b0),
         // reserved codes do nothing
         cmd_row(CMD_RSVD6, 8'hFF, 1'b1, 1'b1, CMD_NONE,  1'b0),
         cmd_row(CMD_RSVD7, 8'h00, 1'b0, 1'b0, CMD_NONE,  1'b0),
         cmd_row(CMD_WRITE, 8'h5A, 1'b1, 1'b0, CMD_RSVD7, 1'b0),
         // zero unit runs as one tick, zero timeout fails on the first poll
         csr_row(16'd0, 8'd0),
         cmd_row(CMD_START, 8'h00, 1'b0, 1'b1, CMD_NONE,  1'b0),
         cmd_row(CMD_WAIT,  8'h00, 1'b0, 1'b1, CMD_NONE,  1'b0),
         cmd_row(CMD_WAIT,  8'h00, 1'b0, 1'b0, CMD_NONE,  1'b0),
         cmd_row(CMD_READ,  8'h00, 1'b1, 1'b0, CMD_WRITE, 1'b0),
         cmd_row(CMD_STOP,  8'h00, 1'b0, 1'b1, CMD_NONE,  1'b0),
         // longest poll
         csr_row(16'd0, 8'd255),
         cmd_row(CMD_WAIT,  8'h00, 1'b0, 1'b1, CMD_NONE,  1'b0),
         // wider unit, run back to back
         csr_row(16'd24, 8'd255),
         cmd_row(CMD_WAIT,  8'h00, 1'b0, 1'b0, CMD_NONE,  1'b1)
      };

      set_unit = '{16'd1, 16'd2, 16'd0, 16'd3, 16'd1, 16'd5, 16'd4};
      set_tmo  = '{8'd250, 8'd3, 8'd1, 8'd0, 8'd255, 8'd12, 8'd7};
      set_unit[N_SETTINGS-1] = 16'($urandom_range(1, 5));
      set_tmo[N_SETTINGS-1]  = 8'($urandom_range(0, 20));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (n = 0; n < N_PLAN; n++) begin
         if (plan[n].is_csr) begin
            configure(plan[n].unit, plan[n].tmo);
         end else begin
            gaps_on = !plan[n].quiet;
            send_tick(plan[n].command, plan[n].tx_byte, plan[n].send_ack, plan[n].sda,
                      plan[n].typed, plan[n].want);
            run_to_idle(plan[n].fill, plan[n].sda);
            gaps_on = 1'b1;
         end
      end

      // random phases, one per setting
      for (int p = 0; p < N_SETTINGS; p++) begin
         configure(set_unit[p], set_tmo[p]);
         gaps_on = (p != 2);
         for (n = 0; n < PHASE_TICKS; n++) begin
            if (seq_phase == PH_IDLE) begin
               pick = $urandom_range(0, 19);
               if (pick < 2) tcmd = CMD_NONE;
               else if (pick == 2) tcmd = $urandom_range(0, 1) ? CMD_RSVD6 : CMD_RSVD7;
               else tcmd = 3'($urandom_range(1, 5));
            end else begin
               tcmd = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : CMD_NONE;
            end
            // sda mostly high while polling so timeouts show up
            tsda = (seq_phase == PH_WA_POLL) ? ($urandom_range(0, 9) != 0)
                                             : 1'($urandom_range(0, 1));
            send_tick(tcmd, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), tsda,
                      1'b0, '0);
         end
         run_to_idle(CMD_NONE, 1'b0);
         gaps_on = 1'b1;
      end

      // drain
      req_tvalid <= 1'b0;
      for (n = 0; n < 1000 && expected_lines.size() > 0; n++) @(posedge clock);
      repeat (8) @(posedge clock);
      if (expected_lines.size() > 0) begin
         $display("tb: %0d expected results never arrived", expected_lines.size());
         fail_count += expected_lines.size();
      end

      $display("tb: %0d ticks sent, %0d results checked, %0d mismatches",
               ticks_sent, results_seen, mismatches);
      $display("tb: taken start %0d stop %0d write %0d read %0d wait %0d, ack timeouts %0d",
               cmd_taken[CMD_START], cmd_taken[CMD_STOP], cmd_taken[CMD_WRITE],
               cmd_taken[CMD_READ], cmd_taken[CMD_WAIT], ack_timeouts);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // result side: random stalls, one long hold-off, field checks
   // ------------------------------------------------------------------
   initial begin
      line_word_t got;
      line_word_t want;
      int         gap;
      bit         held;

      held = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (!held && results_seen >= HOLD_AFTER) begin
            held = 1'b1;
            gap  = HOLD_CYCLES;
         end else begin
            gap = gaps_on ? $urandom_range(0, GAP_MAX) : 0;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got = rsp_tdata;
         results_seen++;
         if (expected_lines.size() == 0) begin
            mismatches++;
            fail_count++;
            if (mismatches <= REPORT_MAX)
               $display("tb: result %h with no transfer pending", got);
         end else begin
            want = expected_lines.pop_front();
            if (got.scl !== want.scl || got.sda !== want.sda || got.busy !== want.busy ||
                got.done !== want.done || got.rx_byte !== want.rx_byte ||
                got.ack_error !== want.ack_error || got.pad !== want.pad) begin
               mismatches++;
               fail_count++;
               if (mismatches <= REPORT_MAX)
                  $display({"tb: result %0d mismatch: expected scl %b sda %b busy %b ",
                            "done %b rx %h err %b, got scl %b sda %b busy %b done %b ",
                            "rx %h err %b pad %b"},
                           results_seen, want.scl, want.sda, want.busy, want.done,
                           want.rx_byte, want.ack_error, got.scl, got.sda, got.busy,
                           got.done, got.rx_byte, got.ack_error, got.pad);
            end
         end
      end
   end

   // run limit
   initial begin
      #20ms;
      $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire

>>> filelist.f
hdl/i2c_mbs_pkg.sv
hdl/i2c_mbs_delay.sv
hdl/i2c_mbs_step.sv
hdl/i2c_master_bit_sequencer.sv
hdl/i2c_mbs_checker.sv
dv/tb.sv
